// File: rtl/core/tmgd_pkg.sv
// Shared types and constants of the tile map gid decoder.
package tmgd_pkg;

  localparam int unsigned GidW     = 31;
  localparam int unsigned ColsW    = 10;
  localparam int unsigned PixW     = 10;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CellColW = 12;
  localparam int unsigned WordW    = 62;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivCntW  = $clog2(GidW);

  localparam logic [DimW-1:0] DimMax = 13'd4096;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_LAYER_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LAYER_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEST_SIZE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TS_COUNT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TS_WORD0     = 3'd4;

  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NO_SET    = 3'd2,
    ST_NO_TEX    = 3'd3,
    ST_OOB       = 3'd4,
    ST_ZERO_COLS = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    M_SY,
    M_SX,
    M_DX,
    M_DY
  } mul_sel_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/core/tmgd_if.sv
// Valid/ready channel interfaces for tile ids in and placement results out.
interface tmgd_in_if import tmgd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [GidW-1:0] tile_gid;
  logic            last_of_layer;

  modport source (output valid, tile_gid, last_of_layer, input ready);
  modport sink   (input valid, tile_gid, last_of_layer, output ready);
endinterface

interface tmgd_out_if import tmgd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [1:0]          set_index;
  logic [CellColW-1:0] cell_col;
  logic [DimW-1:0]     cell_row;
  logic [21:0]         dest_x;
  logic [21:0]         dest_y;
  logic [19:0]         src_x;
  logic [40:0]         src_y;
  logic                is_last;

  modport source (output valid, status, set_index, cell_col, cell_row, dest_x, dest_y,
                  src_x, src_y, is_last, input ready);
  modport sink   (input valid, status, set_index, cell_col, cell_row, dest_x, dest_y,
                  src_x, src_y, is_last, output ready);
endinterface

// File: rtl/core/tile_map_gid_decoder.sv
// Top level of the tile map gid decoder: counters, tileset match, checks and arithmetic.
// A placed tile goes through match, check, 31 divider steps, a wait for the divider to
// report done, four multiplier steps and the load, which waits for the output register.
// Any other tile skips the divider and multiplier and goes from check straight to the load.
// The next transfer is taken the cycle after a result loads, so one tile is in work at a time.
// Reset is asynchronous and active low; it clears counters and handshake, loads defaults.
module tile_map_gid_decoder import tmgd_pkg::*; #(
  parameter int unsigned MAX_TILESETS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [WordW-1:0]     cfg_data_i,
  tmgd_in_if.sink              gid_i,
  tmgd_out_if.source           res_o
);

  localparam int unsigned SetW = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1;

  // Configuration registers.
  logic [DimW-1:0]  layer_w_q, layer_h_q;
  logic [19:0]      dest_size_q;
  logic [2:0]       ts_cnt_q;
  logic [WordW-1:0] ts_word_q [MAX_TILESETS];

  // Position counters.
  logic [CellColW-1:0] col_cnt_q;
  logic [DimW-1:0]     row_cnt_q;

  // Sequencer.
  state_e   state_q, state_d;
  mul_sel_e mul_sel_q;
  logic     div_start, load_out;

  // Item under work.
  logic [GidW-1:0]     gid_q;
  logic                last_q;
  logic [CellColW-1:0] col_item_q;
  logic [DimW-1:0]     row_item_q;
  logic                found_q;
  logic [SetW-1:0]     set_q;
  status_e             status_q;
  logic [PixW-1:0]     sw_q, sh_q;
  logic [21:0]         dx_q, dy_q;
  logic [19:0]         sx_q;
  logic [40:0]         sy_q;

  // Output register.
  logic                out_valid_q;
  status_e             out_status_q;
  logic [1:0]          out_set_q;
  logic [CellColW-1:0] out_col_q;
  logic [DimW-1:0]     out_row_q;
  logic [21:0]         out_dx_q, out_dy_q;
  logic [19:0]         out_sx_q;
  logic [40:0]         out_sy_q;
  logic                out_last_q;

  // Effective dimensions and tileset count: large values clamp; a zero dimension counts as one.
  logic [DimW-1:0] w_eff, h_eff;
  logic [2:0]      n_eff;

  assign w_eff = (layer_w_q == '0) ? DimW'(1) : ((layer_w_q > DimMax) ? DimMax : layer_w_q);
  assign h_eff = (layer_h_q == '0) ? DimW'(1) : ((layer_h_q > DimMax) ? DimMax : layer_h_q);
  assign n_eff = (ts_cnt_q > 3'(MAX_TILESETS)) ? 3'(MAX_TILESETS) : ts_cnt_q;

  logic in_xfer;
  assign in_xfer     = gid_i.valid && gid_i.ready;
  assign gid_i.ready = state_q == S_IDLE;

  // Configuration writes. Tileset words beyond the supported count are dropped.
  logic [1:0] ts_k;
  logic       ts_we;
  assign ts_k  = 2'(cfg_idx_i - REG_TS_WORD0);
  assign ts_we = cfg_we_i && (cfg_idx_i >= REG_TS_WORD0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_w_q   <= DimW'(1);
      layer_h_q   <= DimW'(1);
      dest_size_q <= 20'd16400;
      ts_cnt_q    <= '0;
      for (int k = 0; k < MAX_TILESETS; k++) begin
        ts_word_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LAYER_WIDTH:  layer_w_q   <= cfg_data_i[DimW-1:0];
        REG_LAYER_HEIGHT: layer_h_q   <= cfg_data_i[DimW-1:0];
        REG_DEST_SIZE:    dest_size_q <= cfg_data_i[19:0];
        REG_TS_COUNT:     ts_cnt_q    <= cfg_data_i[2:0];
        default: begin
          for (int k = 0; k < MAX_TILESETS; k++) begin
            if (ts_we && ts_k == 2'(k)) begin
              ts_word_q[k] <= cfg_data_i;
            end
          end
        end
      endcase
    end
  end

  // Row-major position counters advance on each input transfer. The row
  // saturates at the effective height so an overlong stream stays out of bounds.
  logic [DimW-1:0] col_inc;
  assign col_inc = {1'b0, col_cnt_q} + DimW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_xfer) begin
      if (gid_i.last_of_layer) begin
        col_cnt_q <= '0;
        row_cnt_q <= '0;
      end else if (col_inc >= w_eff) begin
        col_cnt_q <= '0;
        row_cnt_q <= (row_cnt_q < h_eff) ? row_cnt_q + DimW'(1) : h_eff;
      end else begin
        col_cnt_q <= col_inc[CellColW-1:0];
      end
    end
  end

  // Tileset match: tileset j hits when the gid is at or above its first id and
  // either j is the last one in use or the gid is below the next first id.
  // The lowest hit wins, even if first ids overlap.
  logic [MAX_TILESETS-1:0] hit;

  for (genvar j = 0; j < MAX_TILESETS; j++) begin : g_match
    logic below_next;
    if (j < MAX_TILESETS - 1) begin : g_nxt
      assign below_next = gid_q < ts_word_q[j+1][GidW-1:0];
    end else begin : g_lst
      assign below_next = 1'b0;
    end
    assign hit[j] = (3'(j) < n_eff) && (gid_q >= ts_word_q[j][GidW-1:0]) &&
                    ((3'(j + 1) == n_eff) || below_next);
  end

  logic [SetW-1:0] hit_sel;
  always_comb begin
    hit_sel = '0;
    for (int j = MAX_TILESETS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_sel = SetW'(j);
      end
    end
  end

  // Checks on the matched tileset, in their order of precedence.
  logic [WordW-1:0] chk_word;
  logic [ColsW-1:0] chk_cols;
  logic [GidW-1:0]  chk_local;
  status_e          chk_status;

  assign chk_word  = ts_word_q[set_q];
  assign chk_cols  = chk_word[40:31];
  assign chk_local = gid_q - chk_word[GidW-1:0];

  always_comb begin
    priority if (gid_q == '0) begin
      chk_status = ST_EMPTY;
    end else if (!found_q) begin
      chk_status = ST_NO_SET;
    end else if (!chk_word[61]) begin
      chk_status = ST_NO_TEX;
    end else if (({1'b0, col_item_q} >= w_eff) || (row_item_q >= h_eff)) begin
      chk_status = ST_OOB;
    end else if (chk_cols == '0) begin
      chk_status = ST_ZERO_COLS;
    end else begin
      chk_status = ST_PLACED;
    end
  end

  // Shared divider for the source tile coordinates.
  div_stat_t        div_stat;
  logic [GidW-1:0]  div_quot;
  logic [ColsW-1:0] div_rem;

  tmgd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (chk_local),
    .divisor_i  (chk_cols),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // One multiplier, used in four steps: source y, source x, destination x and y.
  logic [GidW-1:0] mul_a;
  logic [PixW-1:0] mul_b;
  logic [40:0]     mul_p;

  always_comb begin
    unique case (mul_sel_q)
      M_SY: begin
        mul_a = div_quot;
        mul_b = sh_q;
      end
      M_SX: begin
        mul_a = GidW'(div_rem);
        mul_b = sw_q;
      end
      M_DX: begin
        mul_a = GidW'(col_item_q);
        mul_b = dest_size_q[PixW-1:0];
      end
      M_DY: begin
        mul_a = GidW'(row_item_q);
        mul_b = dest_size_q[2*PixW-1:PixW];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sequencer: next state and control strobes.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (gid_i.valid) begin
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (chk_status == ST_PLACED) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_sel_q == M_DY) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // The result moves into the output register once it is free.
        if (!out_valid_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mul_sel_q <= M_SY;
    end else begin
      state_q <= state_d;
      if (state_q == S_DIV) begin
        mul_sel_q <= M_SY;
      end else if (state_q == S_MUL) begin
        unique case (mul_sel_q)
          M_SY:    mul_sel_q <= M_SX;
          M_SX:    mul_sel_q <= M_DX;
          M_DX:    mul_sel_q <= M_DY;
          default: mul_sel_q <= M_SY;
        endcase
      end
    end
  end

  // Item datapath.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      gid_q      <= gid_i.tile_gid;
      last_q     <= gid_i.last_of_layer;
      col_item_q <= col_cnt_q;
      row_item_q <= row_cnt_q;
    end
    if (state_q == S_MATCH) begin
      found_q <= |hit;
      set_q   <= hit_sel;
    end
    if (state_q == S_CHECK) begin
      status_q <= chk_status;
      sw_q     <= chk_word[50:41];
      sh_q     <= chk_word[60:51];
      dx_q     <= '0;
      dy_q     <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
    end
    if (state_q == S_MUL) begin
      unique case (mul_sel_q)
        M_SY:    sy_q <= mul_p;
        M_SX:    sx_q <= mul_p[19:0];
        M_DX:    dx_q <= mul_p[21:0];
        default: dy_q <= mul_p[21:0];
      endcase
    end
  end

  // Output register; the set index reads zero when no tileset applies.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status_q;
      out_set_q    <= (status_q == ST_EMPTY || status_q == ST_NO_SET) ? 2'd0 : 2'(set_q);
      out_col_q    <= col_item_q;
      out_row_q    <= row_item_q;
      out_dx_q     <= dx_q;
      out_dy_q     <= dy_q;
      out_sx_q     <= sx_q;
      out_sy_q     <= sy_q;
      out_last_q   <= last_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.status    = out_status_q;
  assign res_o.set_index = out_set_q;
  assign res_o.cell_col  = out_col_q;
  assign res_o.cell_row  = out_row_q;
  assign res_o.dest_x    = out_dx_q;
  assign res_o.dest_y    = out_dy_q;
  assign res_o.src_x     = out_sx_q;
  assign res_o.src_y     = out_sy_q;
  assign res_o.is_last   = out_last_q;

`ifndef SYNTHESIS
  a_zero_unless_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status != ST_PLACED |->
      res_o.dest_x == '0 && res_o.dest_y == '0 && res_o.src_x == '0 && res_o.src_y == '0)
    else $error("coordinates nonzero on a result that is not placed");

  a_set_zero_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == ST_EMPTY || res_o.status == ST_NO_SET) |->
      res_o.set_index == 2'd0)
    else $error("set index nonzero without a matched tileset");

  a_row_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> row_cnt_q <= DimMax)
    else $error("row counter past the largest layer height");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  a_xfer_starts_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_MATCH && !div_stat.busy)
    else $error("input transfer did not start a new match");
`endif

endmodule

// File: rtl/core/tmgd_div.sv
// Restoring divider, one quotient bit per cycle, for the local id by the column count.
module tmgd_div import tmgd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [GidW-1:0]  dividend_i,
  input  logic [ColsW-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [GidW-1:0]  quot_o,
  output logic [ColsW-1:0] rem_o
);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [GidW-1:0]    acc_q;
  logic [ColsW-1:0]   rem_q, dvs_q;

  logic [ColsW:0] trial, diff;
  logic           ge;
  logic           last_step;

  assign trial     = {rem_q, acc_q[GidW-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign diff      = trial - {1'b0, dvs_q};
  assign last_step = cnt_q == DivCntW'(GidW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[GidW-2:0], ge};
      rem_q <= ge ? diff[ColsW-1:0] : trial[ColsW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = acc_q;
  assign rem_o       = rem_q;

endmodule

// File: dv/tile_map_gid_decoder_tb.sv
// Self-checking testbench of the tile map gid decoder: placement prediction, random stimulus.
module tile_map_gid_decoder_tb;
  import tmgd_pkg::*;

  localparam int unsigned MaxSets = 4;
  // Cut-off for the run; this leaves a wide margin over a correct run.
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandomTiles = 1750;

  // One placement result as the block reports it.
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  set_index;
    logic [11:0] cell_col;
    logic [12:0] cell_row;
    logic [21:0] dest_x;
    logic [21:0] dest_y;
    logic [19:0] src_x;
    logic [40:0] src_y;
    logic        is_last;
  } placement_t;

  // Keeps its own copy of the registers and the cell counters, works out the
  // placement of every accepted tile id and checks results in order.
  class placement_checker;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [19:0] dest_size_reg;
    logic [2:0]  set_count_reg;
    logic [61:0] set_word [4];
    logic [11:0] col_q;
    logic [12:0] row_q;
    placement_t  pending_placements [$];
    int unsigned mismatches;
    int unsigned status_hits [8];

    function new();
      width_reg     = 13'd1;
      height_reg    = 13'd1;
      dest_size_reg = 20'd16400;
      set_count_reg = 3'd0;
      foreach (set_word[k]) set_word[k] = '0;
      col_q      = '0;
      row_q      = '0;
      mismatches = 0;
      foreach (status_hits[k]) status_hits[k] = 0;
    endfunction

    // Width and height outside 1..4096 are pulled back into that range.
    function int unsigned eff_dim(logic [12:0] v);
      if (v == 13'd0) return 1;
      if (v > 13'd4096) return 4096;
      return int'(v);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
      case (idx)
        REG_LAYER_WIDTH:  width_reg = data[12:0];
        REG_LAYER_HEIGHT: height_reg = data[12:0];
        REG_DEST_SIZE:    dest_size_reg = data[19:0];
        REG_TS_COUNT:     set_count_reg = data[2:0];
        default: begin
          if (idx >= REG_TS_WORD0) set_word[idx - REG_TS_WORD0] = data;
        end
      endcase
    endfunction

    function placement_t place_tile(logic [30:0] gid, logic last);
      placement_t        r;
      int unsigned       w;
      int unsigned       h;
      int unsigned       n;
      int unsigned       j;
      bit                found;
      logic [61:0]       word;
      longint unsigned   local_id;
      longint unsigned   cols;
      longint unsigned   prod;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      n = (set_count_reg > MaxSets) ? MaxSets : set_count_reg;
      r = '0;
      r.cell_col = col_q;
      r.cell_row = row_q;
      r.is_last  = last;
      if (gid == 31'd0) begin
        r.status = ST_EMPTY;
      end else begin
        found = 1'b0;
        for (j = 0; j < n && !found; j++) begin
          if (gid >= set_word[j][30:0] && (j + 1 == n || gid < set_word[j + 1][30:0])) begin
            found       = 1'b1;
            r.set_index = j[1:0];
          end
        end
        if (!found) begin
          r.status = ST_NO_SET;
        end else begin
          word     = set_word[r.set_index];
          cols     = word[40:31];
          local_id = 64'(gid) - 64'(word[30:0]);
          if (!word[61]) begin
            r.status = ST_NO_TEX;
          end else if (col_q >= w || row_q >= h) begin
            r.status = ST_OOB;
          end else if (cols == 0) begin
            r.status = ST_ZERO_COLS;
          end else begin
            r.status = ST_PLACED;
            prod     = 64'(col_q) * 64'(dest_size_reg[9:0]);
            r.dest_x = prod[21:0];
            prod     = 64'(row_q) * 64'(dest_size_reg[19:10]);
            r.dest_y = prod[21:0];
            prod     = (local_id % cols) * 64'(word[50:41]);
            r.src_x  = prod[19:0];
            prod     = (local_id / cols) * 64'(word[60:51]);
            r.src_y  = prod[40:0];
          end
        end
      end
      // Row-major advance; the row count sticks at the layer height.
      if (last) begin
        col_q = '0;
        row_q = '0;
      end else if (col_q + 1 >= w) begin
        col_q = '0;
        row_q = (row_q < h) ? row_q + 13'd1 : h[12:0];
      end else begin
        col_q = col_q + 12'd1;
      end
      return r;
    endfunction

    function void note_tile(logic [30:0] gid, logic last);
      pending_placements = {pending_placements, place_tile(gid, last)};
    endfunction

    function string show(placement_t r);
      return $sformatf("status=%0d set=%0d col=%0d row=%0d dx=%0d dy=%0d sx=%0d sy=%0d last=%0b",
                       r.status, r.set_index, r.cell_col, r.cell_row, r.dest_x, r.dest_y,
                       r.src_x, r.src_y, r.is_last);
    endfunction

    function void check_placement(placement_t got);
      placement_t want;
      if (pending_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = pending_placements.pop_front();
      status_hits[want.status]++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("placement mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int unsigned pending_count();
      return pending_placements.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [WordW-1:0]    cfg_data_i;

  tmgd_in_if  gid_if ();
  tmgd_out_if res_if ();

  tile_map_gid_decoder #(
    .MAX_TILESETS(MaxSets)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .gid_i     (gid_if),
    .res_o     (res_if)
  );

  placement_checker sb = new();

  // Per-phase switches for random gaps on each side of the block.
  bit          send_idle_on;
  bit          recv_idle_on;
  // First ids of the tilesets currently loaded, used to aim tile ids at them.
  logic [30:0] phase_first [4];
  // Tileset words staged for the next register setting.
  logic [61:0] next_words [4];
  int unsigned tiles_sent;
  int unsigned settings_done;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The run is cut off if it hangs; a correct run ends far earlier.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d placements still due", cycle_count,
             sb.pending_count());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: ready drops for a random number of cycles before each transfer
  // when stalls are enabled, and otherwise stays high.
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
    end
  end

  // Every result transfer is checked against the oldest predicted placement.
  // Signals are read right at the edge, before this edge's updates land.
  always @(posedge clk_i) begin
    placement_t seen;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      seen.status    = res_if.status;
      seen.set_index = res_if.set_index;
      seen.cell_col  = res_if.cell_col;
      seen.cell_row  = res_if.cell_row;
      seen.dest_x    = res_if.dest_x;
      seen.dest_y    = res_if.dest_y;
      seen.src_x     = res_if.src_x;
      seen.src_y     = res_if.src_y;
      seen.is_last   = res_if.is_last;
      sb.check_placement(seen);
    end
  end

  // Presents one tile id and holds it until the block takes it. With no gap the
  // valid stays high from the previous transfer, so it is never dropped and
  // raised within one step.
  task automatic send_tile(logic [30:0] gid, logic last);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      gid_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    gid_if.valid         <= 1'b1;
    gid_if.tile_gid      <= gid;
    gid_if.last_of_layer <= last;
    do @(posedge clk_i); while (gid_if.ready !== 1'b1);
    sb.note_tile(gid, last);
    tiles_sent++;
  endtask

  // Stops the input and waits for every predicted placement, then a few more
  // cycles so that the block is surely idle.
  task automatic drain_results();
    gid_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Loads a complete register setting while the block is idle. The tileset
  // words come from next_words.
  task automatic apply_config(logic [12:0] w, logic [12:0] h, logic [19:0] dsz,
                              logic [2:0] cnt);
    drain_results();
    write_reg(REG_LAYER_WIDTH, WordW'(w));
    write_reg(REG_LAYER_HEIGHT, WordW'(h));
    write_reg(REG_DEST_SIZE, WordW'(dsz));
    write_reg(REG_TS_COUNT, WordW'(cnt));
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_TS_WORD0 + CfgIdxW'(k), next_words[k]);
      phase_first[k] = next_words[k][30:0];
    end
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  function automatic logic [61:0] make_word(logic [30:0] first, logic [9:0] cols,
                                            logic [9:0] sw, logic [9:0] sh, logic tex);
    return {tex, sh, sw, cols, first};
  endfunction

  // Layer sizes: mostly a handful of tiles so rows wrap and overflow often,
  // with the range ends and out-of-range values mixed in.
  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 9))
      5:       return 13'd1;
      6:       return 13'd4096;
      7:       return 13'($urandom_range(7, 4096));
      8:       return 13'd0;
      9:       return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [9:0] pick_pix();
    case ($urandom_range(0, 5))
      0:       return 10'd0;
      1:       return 10'd1023;
      default: return 10'($urandom);
    endcase
  endfunction

  // One random register setting followed by layers of tile ids. Most layers are
  // well formed, a full layer closed by the last mark; some run past the end
  // of the layer, some close early, and some leave the mark off so the counters
  // carry into the next setting.
  task automatic random_phase();
    logic [30:0] f;
    logic [30:0] gid;
    logic [12:0] w;
    logic [12:0] h;
    logic [19:0] dsz;
    logic [9:0]  cols;
    int unsigned target;
    int unsigned done_tiles;
    int unsigned cells;
    int unsigned len;
    int unsigned k;
    bit          with_last;
    w = pick_dim();
    h = pick_dim();
    case ($urandom_range(0, 4))
      0:       dsz = 20'hFFFFF;
      1:       dsz = 20'h0;
      default: dsz = 20'($urandom);
    endcase
    f = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 64));
    for (k = 0; k < 4; k++) begin
      case ($urandom_range(0, 7))
        0:       cols = 10'd0;
        1:       cols = 10'd1023;
        2:       cols = 10'd1;
        default: cols = 10'($urandom_range(2, 40));
      endcase
      next_words[k] = make_word(f, cols, pick_pix(), pick_pix(), $urandom_range(0, 7) != 0);
      // Mostly ascending first ids; now and then one that overlaps an earlier set.
      f = ($urandom_range(0, 7) == 0) ? 31'($urandom_range(0, f)) :
                                        31'(f + $urandom_range(1, 300));
    end
    send_idle_on = $urandom_range(0, 3) != 0;
    recv_idle_on = $urandom_range(0, 3) != 0;
    apply_config(w, h, dsz, ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 4))
                                                         : 3'($urandom_range(0, 7)));
    target     = $urandom_range(20, 150);
    done_tiles = 0;
    cells      = sb.eff_dim(w) * sb.eff_dim(h);
    while (done_tiles < target) begin
      case ($urandom_range(0, 9))
        7, 8:    len = cells + $urandom_range(1, 4);
        9:       len = $urandom_range(1, cells);
        default: len = cells;
      endcase
      if (len > 120) len = $urandom_range(1, 120);
      with_last = $urandom_range(0, 9) != 0;
      for (int i = 1; i <= len; i++) begin
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 19))
          0:       gid = 31'd0;
          1:       gid = 31'($urandom);
          2:       gid = 31'h7FFF_FFFF;
          3:       gid = phase_first[k] - 31'd1;
          4:       gid = phase_first[k] + 31'($urandom_range(0, 1 << 20));
          default: gid = phase_first[k] + 31'($urandom_range(0, 200));
        endcase
        send_tile(gid, with_last && (i == len));
      end
      done_tiles += len;
      // Occasionally let everything drain in the middle of a setting.
      if ($urandom_range(0, 19) == 0) drain_results();
    end
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= REG_LAYER_WIDTH;
    cfg_data_i           <= '0;
    gid_if.valid         <= 1'b0;
    gid_if.tile_gid      <= '0;
    gid_if.last_of_layer <= 1'b0;
    send_idle_on  = 1'b1;
    recv_idle_on  = 1'b1;
    tiles_sent    = 0;
    settings_done = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a 3x2 layer with four tilesets, the largest destination tile,
    // the largest columns and source tile size, and ids at both ends.
    next_words[0] = make_word(31'd1, 10'd1023, 10'd1023, 10'd1023, 1'b1);
    next_words[1] = make_word(31'd2000, 10'd0, 10'd5, 10'd5, 1'b1);
    next_words[2] = make_word(31'd3000, 10'd4, 10'd6, 10'd6, 1'b0);
    next_words[3] = make_word(31'h7FFF_FF00, 10'd3, 10'd7, 10'd1023, 1'b1);
    apply_config(13'd3, 13'd2, 20'hFFFFF, 3'd4);
    send_tile(31'd0, 1'b0);           // empty cell
    send_tile(31'd1, 1'b0);           // first id of the first set
    send_tile(31'd1023, 1'b0);        // largest remainder times the widest source tile
    send_tile(31'd2000, 1'b0);        // set without columns
    send_tile(31'd3000, 1'b0);        // set without texture
    send_tile(31'h7FFF_FFFF, 1'b0);   // largest id, falls to the last set
    send_tile(31'h7FFF_FF00, 1'b0);   // past the last row of the layer
    send_tile(31'd2500, 1'b0);        // out of bounds wins over zero columns
    send_tile(31'd1, 1'b0);           // row count held at the height
    send_tile(31'd5, 1'b1);           // last mark clears the counters
    send_tile(31'd1, 1'b0);
    send_tile(31'd2, 1'b0);           // leaves the column counter at 2

    // Directed: width lowered under the column counter mid-layer, a 1x1 layer,
    // zero destination size, and two sets whose first ids are out of order.
    next_words[0] = make_word(31'd50, 10'd1, 10'd1, 10'd1, 1'b1);
    next_words[1] = make_word(31'd10, 10'd2, 10'd5, 10'd5, 1'b1);
    next_words[2] = make_word(31'h7FFF_FFFF, 10'd1023, 10'd1023, 10'd1023, 1'b1);
    next_words[3] = '0;
    apply_config(13'd1, 13'd1, 20'h0, 3'd2);
    send_tile(31'd60, 1'b0);
    send_tile(31'd30, 1'b0);
    send_tile(31'd5, 1'b1);           // below every first id in use
    send_tile(31'd30, 1'b1);
    send_tile(31'd60, 1'b1);          // the out-of-order second set wins

    // Directed: no tilesets in use, with width and height out of range.
    next_words[0] = {62{1'b1}};
    next_words[1] = {62{1'b1}};
    next_words[2] = {62{1'b1}};
    next_words[3] = {62{1'b1}};
    apply_config(13'd8191, 13'd0, 20'hFFFFF, 3'd0);
    send_tile(31'd5, 1'b0);
    send_tile(31'd0, 1'b0);
    send_tile(31'h7FFF_FFFF, 1'b1);

    // Directed: a set count above the maximum, a first id of zero.
    next_words[0] = make_word(31'd0, 10'd1023, 10'd3, 10'd3, 1'b1);
    next_words[1] = make_word(31'd10, 10'd1023, 10'd3, 10'd3, 1'b1);
    next_words[2] = make_word(31'd20, 10'd1023, 10'd3, 10'd3, 1'b1);
    next_words[3] = make_word(31'd30, 10'd1023, 10'd1023, 10'd1023, 1'b1);
    apply_config(13'd0, 13'd8191, 20'hFFFFF, 3'd7);
    send_tile(31'd5, 1'b0);
    send_tile(31'd15, 1'b0);
    send_tile(31'd25, 1'b0);
    send_tile(31'h7FFF_FFFF, 1'b1);

    // Random settings and layers until enough tile ids have gone in.
    while (tiles_sent < RandomTiles) random_phase();

    drain_results();
    repeat (40) @(posedge clk_i);

    $display("Sent %0d tile ids under %0d register settings in %0d cycles.", tiles_sent,
             settings_done, cycle_count);
    $display("Results: placed %0d, empty %0d, no set %0d, no texture %0d, %0s %0d, %0s %0d.",
             sb.status_hits[ST_PLACED], sb.status_hits[ST_EMPTY], sb.status_hits[ST_NO_SET],
             sb.status_hits[ST_NO_TEX], "out of bounds", sb.status_hits[ST_OOB],
             "zero columns", sb.status_hits[ST_ZERO_COLS]);
    if (sb.pending_count() != 0)
      $display("%0d predicted placements never arrived", sb.pending_count());
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
